[design/ofiw_pkg.sv]
// ============================================================================
// ofiw_pkg
// Shared types, widths and constants for the rolling order flow imbalance
// block: payload structs, queue command, window control and status.
// ============================================================================
package ofiw_pkg;

	localparam int unsigned PRICE_W   = 32;
	localparam int unsigned VOL_W     = 32;
	localparam int unsigned TIME_W    = 64;
	localparam int unsigned IMB_W     = VOL_W + 2;
	localparam int unsigned SUM_W     = 48;
	localparam int unsigned CFG_W     = 36;
	localparam int unsigned CFG_IDX_W = 2;

	localparam int unsigned WINDOW_DEPTH_DEF = 1024;

	// Register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MID   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG  = 2'd2;

	// Window age limits after reset, in ns
	localparam logic [CFG_W-1:0] SHORT_RST = 36'd1000000000;
	localparam logic [CFG_W-1:0] MID_RST   = 36'd5000000000;
	localparam logic [CFG_W-1:0] LONG_RST  = 36'd30000000000;

	typedef struct packed {
		logic [TIME_W-1:0]  event_time;
		logic [PRICE_W-1:0] bid_price;
		logic [VOL_W-1:0]   bid_volume;
		logic [PRICE_W-1:0] ask_price;
		logic [VOL_W-1:0]   ask_volume;
	} in_item_t;

	typedef struct packed {
		logic signed [IMB_W-1:0] imbalance;
		logic signed [SUM_W-1:0] sum_short;
		logic signed [SUM_W-1:0] sum_mid;
		logic signed [SUM_W-1:0] sum_long;
		logic                    event_recorded;
		logic                    priming_only;
		logic                    overflow_evicted;
	} out_item_t;

	// Classified quote, passed from front to back
	typedef struct packed {
		logic [TIME_W-1:0] event_time;
		logic [IMB_W-1:0]  imbalance;
		logic              priming;
		logic              record;
	} cmd_t;

	// Control into one window engine
	typedef struct packed {
		logic              start;
		logic              push;
		logic [TIME_W-1:0] event_time;
		logic [IMB_W-1:0]  value;
	} win_cmd_t;

	// Status out of one window engine
	typedef struct packed {
		logic             busy;
		logic             evicted;
		logic [SUM_W-1:0] total;
	} win_stat_t;

	// Sign-extend an imbalance to the width of a running sum
	function automatic logic [SUM_W-1:0] imb_to_sum(input logic [IMB_W-1:0] v);
		return {{(SUM_W-IMB_W){v[IMB_W-1]}}, v};
	endfunction

endpackage

[design/ofiw_ram.sv]
// ============================================================================
// ofiw_ram
// Generic single-write, single-read RAM with registered read data.
// ============================================================================
module ofiw_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port, holds when not reading
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

[design/ofiw_front.sv]
// ============================================================================
// ofiw_front
// Accepts quotes, computes the imbalance against the stored quote and
// classifies each transaction as priming, recorded or zero-imbalance.
// ============================================================================
module ofiw_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  ofiw_pkg::in_item_t in_data,
	input  logic               q_full,
	output logic               q_push,
	output ofiw_pkg::cmd_t     q_cmd
);
	import ofiw_pkg::*;

	logic [PRICE_W-1:0] last_bp_q;
	logic [VOL_W-1:0]   last_bv_q;
	logic [PRICE_W-1:0] last_ap_q;
	logic [VOL_W-1:0]   last_av_q;
	logic               primed_q;

	logic [IMB_W-1:0] bv_ext;
	logic [IMB_W-1:0] av_ext;
	logic [IMB_W-1:0] last_bv_ext;
	logic [IMB_W-1:0] last_av_ext;
	logic [IMB_W-1:0] bid_delta;
	logic [IMB_W-1:0] ask_delta;
	logic [IMB_W-1:0] ofi;

	assign in_stall = q_full;
	assign q_push   = in_valid && !q_full;

	assign bv_ext      = {{(IMB_W-VOL_W){1'b0}}, in_data.bid_volume};
	assign av_ext      = {{(IMB_W-VOL_W){1'b0}}, in_data.ask_volume};
	assign last_bv_ext = {{(IMB_W-VOL_W){1'b0}}, last_bv_q};
	assign last_av_ext = {{(IMB_W-VOL_W){1'b0}}, last_av_q};

	// Bid side: improved counts new volume, held counts the difference
	always_comb begin
		if (in_data.bid_price > last_bp_q) begin
			bid_delta = bv_ext;
		end else if (in_data.bid_price == last_bp_q) begin
			bid_delta = bv_ext - last_bv_ext;
		end else begin
			bid_delta = '0 - last_bv_ext;
		end
	end

	// Ask side: a lower ask is the improvement
	always_comb begin
		if (in_data.ask_price < last_ap_q) begin
			ask_delta = av_ext;
		end else if (in_data.ask_price == last_ap_q) begin
			ask_delta = av_ext - last_av_ext;
		end else begin
			ask_delta = '0 - last_av_ext;
		end
	end

	assign ofi = bid_delta - ask_delta;

	// Build the command for the back end
	always_comb begin
		q_cmd.event_time = in_data.event_time;
		q_cmd.imbalance  = primed_q ? ofi : '0;
		q_cmd.priming    = !primed_q;
		q_cmd.record     = primed_q && (ofi != '0);
	end

	// Store the quote on every accepted transaction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_bp_q <= '0;
			last_bv_q <= '0;
			last_ap_q <= '0;
			last_av_q <= '0;
			primed_q  <= 1'b0;
		end else if (q_push) begin
			last_bp_q <= in_data.bid_price;
			last_bv_q <= in_data.bid_volume;
			last_ap_q <= in_data.ask_price;
			last_av_q <= in_data.ask_volume;
			primed_q  <= 1'b1;
		end
	end

endmodule

[design/ofiw_cmd_queue.sv]
// ============================================================================
// ofiw_cmd_queue
// Two-entry command queue that decouples the front end from the back end.
// ============================================================================
module ofiw_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  ofiw_pkg::cmd_t cmd_in,
	output logic           full,
	input  logic           pop,
	output logic           valid,
	output ofiw_pkg::cmd_t cmd_out
);
	import ofiw_pkg::*;

	localparam int unsigned QDEPTH = 2;
	localparam int unsigned PW     = $clog2(QDEPTH);

	cmd_t          entry_q [QDEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [PW:0]   count_q;

	assign full    = (count_q == (PW+1)'(QDEPTH));
	assign valid   = (count_q != '0);
	assign cmd_out = entry_q[rd_ptr_q];

	// Store the entry
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= cmd_in;
		end
	end

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

[design/ofiw_window.sv]
// ============================================================================
// ofiw_window
// One rolling time window: a circular FIFO of (time, imbalance) entries in
// RAM with a running total. Pushes, evicts when full, then retires entries
// older than the age limit, one per cycle.
// ============================================================================
module ofiw_window #(
	parameter int unsigned WINDOW_DEPTH = ofiw_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  ofiw_pkg::win_cmd_t         cmd,
	input  logic [ofiw_pkg::CFG_W-1:0] limit,
	output ofiw_pkg::win_stat_t        stat
);
	import ofiw_pkg::*;

	localparam int unsigned AW      = $clog2(WINDOW_DEPTH);
	localparam int unsigned ENTRY_W = TIME_W + IMB_W;
	localparam logic [AW:0] DEPTH_C = (AW+1)'(WINDOW_DEPTH);
	localparam logic [AW:0] ONE_C   = (AW+1)'(1);

	typedef enum logic [3:0] {
		W_IDLE  = 4'b0001,
		W_EVICT = 4'b0010,
		W_RD    = 4'b0100,
		W_CHK   = 4'b1000
	} wstate_t;

	wstate_t           state_q;
	logic [AW-1:0]     head_q;
	logic [AW:0]       count_q;
	logic [SUM_W-1:0]  total_q;
	logic              evicted_q;
	logic [TIME_W-1:0] now_q;
	logic [IMB_W-1:0]  val_q;

	logic               we;
	logic               re;
	logic [AW-1:0]      waddr;
	logic [AW-1:0]      raddr;
	logic [ENTRY_W-1:0] wdata;
	logic [ENTRY_W-1:0] rdata;

	logic [AW-1:0]     head_next;
	logic [AW:0]       tail_sum;
	logic [AW-1:0]     tail;
	logic              full;
	logic [TIME_W-1:0] rd_time;
	logic [IMB_W-1:0]  rd_val;
	logic [TIME_W-1:0] age;
	logic              expired;

	ofiw_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (WINDOW_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (re),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Circular index arithmetic
	assign head_next = (head_q == AW'(WINDOW_DEPTH-1)) ? '0 : head_q + 1'b1;
	assign tail_sum  = {1'b0, head_q} + count_q;
	assign tail      = (tail_sum >= DEPTH_C) ? AW'(tail_sum - DEPTH_C) : tail_sum[AW-1:0];
	assign full      = (count_q == DEPTH_C);

	// Age of the oldest entry, unsigned wrap on time going backwards
	assign rd_time = rdata[ENTRY_W-1 -: TIME_W];
	assign rd_val  = rdata[IMB_W-1:0];
	assign age     = now_q - rd_time;
	assign expired = age > {{(TIME_W-CFG_W){1'b0}}, limit};

	// RAM port control
	always_comb begin
		we    = 1'b0;
		waddr = tail;
		wdata = {cmd.event_time, cmd.value};
		re    = 1'b0;
		raddr = head_q;
		unique case (state_q)
			W_IDLE: begin
				if (cmd.start && cmd.push) begin
					re = full;
					we = !full;
				end
			end
			W_EVICT: begin
				// New entry lands in the slot of the evicted one
				we    = 1'b1;
				waddr = head_q;
				wdata = {now_q, val_q};
			end
			W_RD: begin
				re = (count_q != '0);
			end
			W_CHK: begin
				// Fetch the next oldest while retiring this one
				if (expired && (count_q != ONE_C)) begin
					re    = 1'b1;
					raddr = head_next;
				end
			end
			default: begin
			end
		endcase
	end

	// Hold the command time and value for the pass
	always_ff @(posedge clk) begin
		if ((state_q == W_IDLE) && cmd.start) begin
			now_q <= cmd.event_time;
			val_q <= cmd.value;
		end
	end

	// Sequence push, evict and prune
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= W_IDLE;
			head_q    <= '0;
			count_q   <= '0;
			total_q   <= '0;
			evicted_q <= 1'b0;
		end else begin
			unique case (state_q)
				W_IDLE: begin
					if (cmd.start) begin
						evicted_q <= 1'b0;
						state_q   <= W_RD;
						if (cmd.push) begin
							if (full) begin
								evicted_q <= 1'b1;
								state_q   <= W_EVICT;
							end else begin
								count_q <= count_q + 1'b1;
								total_q <= total_q + imb_to_sum(cmd.value);
							end
						end
					end
				end
				W_EVICT: begin
					total_q <= total_q - imb_to_sum(rd_val) + imb_to_sum(val_q);
					head_q  <= head_next;
					state_q <= W_RD;
				end
				W_RD: begin
					state_q <= (count_q != '0) ? W_CHK : W_IDLE;
				end
				W_CHK: begin
					if (expired) begin
						total_q <= total_q - imb_to_sum(rd_val);
						head_q  <= head_next;
						count_q <= count_q - 1'b1;
						state_q <= (count_q == ONE_C) ? W_IDLE : W_CHK;
					end else begin
						state_q <= W_IDLE;
					end
				end
				default: begin
					state_q <= W_IDLE;
				end
			endcase
		end
	end

	always_comb begin
		stat.busy    = (state_q != W_IDLE);
		stat.evicted = evicted_q;
		stat.total   = total_q;
	end

endmodule

[design/ofiw_back.sv]
// ============================================================================
// ofiw_back
// Takes classified commands from the queue, runs the three window engines
// in parallel and loads the result into the output register.
// ============================================================================
module ofiw_back #(
	parameter int unsigned WINDOW_DEPTH = ofiw_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       q_valid,
	input  ofiw_pkg::cmd_t             q_cmd,
	output logic                       q_pop,
	input  logic [ofiw_pkg::CFG_W-1:0] short_limit,
	input  logic [ofiw_pkg::CFG_W-1:0] mid_limit,
	input  logic [ofiw_pkg::CFG_W-1:0] long_limit,
	output logic                       out_valid,
	input  logic                       out_stall,
	output ofiw_pkg::out_item_t        out_data
);
	import ofiw_pkg::*;

	typedef enum logic [1:0] {
		B_IDLE = 2'b01,
		B_WAIT = 2'b10
	} bstate_t;

	bstate_t   state_q;
	cmd_t      cmd_q;
	logic      out_valid_q;
	out_item_t out_data_q;

	win_cmd_t  win_cmd;
	win_stat_t stat_short;
	win_stat_t stat_mid;
	win_stat_t stat_long;
	logic      all_idle;
	logic      out_free;
	logic      load;

	// Dispatch: priming quotes leave the windows untouched
	assign q_pop = (state_q == B_IDLE) && q_valid;

	always_comb begin
		win_cmd.start      = q_pop && !q_cmd.priming;
		win_cmd.push       = q_cmd.record;
		win_cmd.event_time = q_cmd.event_time;
		win_cmd.value      = q_cmd.imbalance;
	end

	ofiw_window #(.WINDOW_DEPTH (WINDOW_DEPTH)) u_short (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (win_cmd),
		.limit  (short_limit),
		.stat   (stat_short)
	);

	ofiw_window #(.WINDOW_DEPTH (WINDOW_DEPTH)) u_mid (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (win_cmd),
		.limit  (mid_limit),
		.stat   (stat_mid)
	);

	ofiw_window #(.WINDOW_DEPTH (WINDOW_DEPTH)) u_long (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (win_cmd),
		.limit  (long_limit),
		.stat   (stat_long)
	);

	assign all_idle = !stat_short.busy && !stat_mid.busy && !stat_long.busy;
	assign out_free = !out_valid_q || !out_stall;
	assign load     = (state_q == B_WAIT) && all_idle && out_free;

	// Hold the command under way
	always_ff @(posedge clk) begin
		if (q_pop) begin
			cmd_q <= q_cmd;
		end
	end

	// Control: dispatch, then wait for all windows and a free output slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= B_IDLE;
		end else begin
			unique case (state_q)
				B_IDLE: begin
					if (q_valid) begin
						state_q <= B_WAIT;
					end
				end
				B_WAIT: begin
					if (load) begin
						state_q <= B_IDLE;
					end
				end
				default: begin
					state_q <= B_IDLE;
				end
			endcase
		end
	end

	// Output register payload
	always_ff @(posedge clk) begin
		if (load) begin
			out_data_q.imbalance        <= cmd_q.imbalance;
			out_data_q.sum_short        <= stat_short.total;
			out_data_q.sum_mid          <= stat_mid.total;
			out_data_q.sum_long         <= stat_long.total;
			out_data_q.event_recorded   <= cmd_q.record;
			out_data_q.priming_only     <= cmd_q.priming;
			out_data_q.overflow_evicted <= cmd_q.record &&
				(stat_short.evicted || stat_mid.evicted || stat_long.evicted);
		end
	end

	// Output valid: set on load, drop once taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

[design/order_flow_imbalance_windows.sv]
// ============================================================================
// order_flow_imbalance_windows
// Order flow imbalance of best bid/ask quotes, summed over three rolling
// time windows (short, mid, long) held in RAM-based FIFOs.
//
//   channel  direction  handshake            payload
//   in       input      in_valid / in_stall  in_data   (ofiw_pkg::in_item_t)
//   out      output     out_valid/out_stall  out_data  (ofiw_pkg::out_item_t)
//   cfg      input      cfg_we               cfg_index, cfg_wdata
//
// A quote is classified in the front end and queued. In the back end each
// window pushes a recorded quote, evicts the oldest entry when full and
// then retires expired entries, one entry per cycle through its RAM read
// port; the result is loaded once all three windows are idle. A priming
// quote leaves the windows untouched.
// Reset clears all control state at once; the window RAMs are not cleared.
// A stalled output holds its register while the next quote is processed;
// the two-entry command queue stalls the input only when it is full.
// ============================================================================
module order_flow_imbalance_windows #(
	parameter int unsigned WINDOW_DEPTH = ofiw_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  ofiw_pkg::in_item_t             in_data,
	output logic                           out_valid,
	input  logic                           out_stall,
	output ofiw_pkg::out_item_t            out_data,
	input  logic                           cfg_we,
	input  logic [ofiw_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [ofiw_pkg::CFG_W-1:0]     cfg_wdata
);
	import ofiw_pkg::*;

	logic [CFG_W-1:0] short_window_q;
	logic [CFG_W-1:0] mid_window_q;
	logic [CFG_W-1:0] long_window_q;

	logic q_full;
	logic q_push;
	cmd_t q_cmd_in;
	logic q_valid;
	logic q_pop;
	cmd_t q_cmd_out;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_window_q <= SHORT_RST;
			mid_window_q   <= MID_RST;
			long_window_q  <= LONG_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_SHORT: short_window_q <= cfg_wdata;
				CFG_MID:   mid_window_q   <= cfg_wdata;
				CFG_LONG:  long_window_q  <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	ofiw_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.in_data  (in_data),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_cmd    (q_cmd_in)
	);

	ofiw_cmd_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (q_push),
		.cmd_in  (q_cmd_in),
		.full    (q_full),
		.pop     (q_pop),
		.valid   (q_valid),
		.cmd_out (q_cmd_out)
	);

	ofiw_back #(.WINDOW_DEPTH (WINDOW_DEPTH)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_cmd       (q_cmd_out),
		.q_pop       (q_pop),
		.short_limit (short_window_q),
		.mid_limit   (mid_window_q),
		.long_limit  (long_window_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

`ifndef SYNTH
	// A recorded event carries a nonzero imbalance and is never a priming quote
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.event_recorded |->
			(out_data.imbalance != '0) && !out_data.priming_only)
		else $error("recorded event with zero imbalance or priming flag");

	// Eviction happens only on a push
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.overflow_evicted |-> out_data.event_recorded)
		else $error("eviction flagged without a recorded event");

	// A priming quote reports no imbalance
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.priming_only |-> (out_data.imbalance == '0))
		else $error("priming quote with nonzero imbalance");

	// A stalled result stays valid and holds its payload until taken
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("stalled result changed or dropped");
`endif

endmodule
